// ===== sv/pjcs_pkg.sv =====
// Package for the parallel job core scheduler: field widths, the controller
// states, the cell operation codes, the cell control struct and the link struct passed along the cell ring.
// No dependencies.
`default_nettype none

package pjcs_pkg;

    localparam int ID_W          = 16;
    localparam int TIME_W        = 32;
    localparam int WANT_W        = 6;
    localparam int CORE_W        = 4;
    localparam int CMP_W         = WANT_W + 1;
    localparam int DEF_NUM_CORES = 16;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_COUNT,
        ST_MARK,
        ST_PICK,
        ST_CALC,
        ST_ASSIGN
    } t_state;

    // Operation applied to every cell at once
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_COUNT,
        CELL_MARK,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [WANT_W-1:0]   rank;
    } t_cell_ctrl;

    // Data a cell hands to its left neighbor
    typedef struct packed {
        logic [TIME_W-1:0]   free_time;
        logic [TIME_W-1:0]   trav;
        logic                flag;
    } t_cell_link;

endpackage

`default_nettype wire

// ===== sv/pjcs_cell.sv =====
// One scheduler cell: holds the free time of one core, counts rank against
// values passing on the ring, and rotates its contents to its left neighbor.
// Depends on pjcs_pkg.
`default_nettype none

module pjcs_cell #(
    parameter int CNT_W = 5
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire pjcs_pkg::t_cell_ctrl  i_ctrl,
    input  wire pjcs_pkg::t_cell_link  i_next,
    output pjcs_pkg::t_cell_link       o_link
);
    import pjcs_pkg::*;

    logic [TIME_W-1:0] r_free_time, n_free_time;
    logic [TIME_W-1:0] r_trav, n_trav;
    logic [CNT_W-1:0]  r_below, n_below;
    logic [CNT_W-1:0]  r_at_below, n_at_below;
    logic              r_flag, n_flag;
    logic              rank_hit;

    // Rank test: this value sits at the requested rank
    assign rank_hit = (CMP_W'(r_below) < CMP_W'(i_ctrl.rank)) &&
                      (CMP_W'(i_ctrl.rank) <= CMP_W'(r_at_below));

    // Apply the cycle's operation
    always_comb begin
        n_free_time = r_free_time;
        n_trav      = r_trav;
        n_below     = r_below;
        n_at_below  = r_at_below;
        n_flag      = r_flag;
        case (i_ctrl.op)
            CELL_LOAD: begin
                n_trav     = r_free_time;
                n_below    = '0;
                n_at_below = '0;
            end
            CELL_COUNT: begin
                n_below    = r_below + CNT_W'(r_trav < r_free_time);
                n_at_below = r_at_below + CNT_W'(r_trav <= r_free_time);
                n_trav     = i_next.trav;
            end
            CELL_MARK: begin
                n_flag = rank_hit;
            end
            CELL_ROTATE: begin
                n_free_time = i_next.free_time;
                n_flag      = i_next.flag;
            end
            default: begin
            end
        endcase
    end

    // Free time is architectural state and clears on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_time <= '0;
        end else begin
            r_free_time <= n_free_time;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_trav     <= n_trav;
        r_below    <= n_below;
        r_at_below <= n_at_below;
        r_flag     <= n_flag;
    end

    assign o_link.free_time = r_free_time;
    assign o_link.trav      = r_trav;
    assign o_link.flag      = r_flag;

endmodule

`default_nettype wire

// ===== sv/parallel_job_core_scheduler.sv =====
// Parallel job core scheduler: a ring of NUM_CORES cells, one per core.
// Per job: a rank counting pass over the ring, a mark step, a pass to collect the
// ranked value, a step to form the start time, then NUM_CORES assignment steps,
// one per cycle unless the output stalls. A rejected job skips these and emits a
// single error result. One job is worked on at a time; no input is taken until it is done.
// Synchronous active-low reset clears all core free times at once; no clearing pass.
`default_nettype none

module parallel_job_core_scheduler #(
    parameter int NUM_CORES = pjcs_pkg::DEF_NUM_CORES
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [pjcs_pkg::ID_W-1:0]      i_job_id,
    input  wire  [pjcs_pkg::TIME_W-1:0]    i_arrival_time,
    input  wire  [pjcs_pkg::WANT_W-1:0]    i_cores_wanted,
    input  wire  [pjcs_pkg::TIME_W-1:0]    i_run_time,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [pjcs_pkg::ID_W-1:0]      o_out_job_id,
    output logic [pjcs_pkg::TIME_W-1:0]    o_start_time,
    output logic [pjcs_pkg::TIME_W-1:0]    o_end_time,
    output logic [pjcs_pkg::CORE_W-1:0]    o_core_index,
    output logic                           o_last,
    output logic                           o_error
);
    import pjcs_pkg::*;

    localparam int CW    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int KW    = $clog2(NUM_CORES + 1);
    localparam logic [CMP_W-1:0] NC_LIMIT = CMP_W'(NUM_CORES);
    localparam logic [CW-1:0]    STEP_END = CW'(NUM_CORES - 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_step, n_step;
    logic [KW-1:0]       r_left, n_left;
    logic [ID_W-1:0]     r_job_id, n_job_id;
    logic [TIME_W-1:0]   r_arrival, n_arrival;
    logic [WANT_W-1:0]   r_want, n_want;
    logic [TIME_W-1:0]   r_run, n_run;
    logic [TIME_W-1:0]   r_kth, n_kth;
    logic [TIME_W-1:0]   r_start, n_start;

    logic                r_out_valid, n_out_valid;
    logic [ID_W-1:0]     r_out_job_id, n_out_job_id;
    logic [TIME_W-1:0]   r_out_start, n_out_start;
    logic [TIME_W-1:0]   r_out_end, n_out_end;
    logic [CORE_W-1:0]   r_out_core, n_out_core;
    logic                r_out_last, n_out_last;
    logic                r_out_error, n_out_error;

    logic                in_accept;
    logic                bad_want;
    logic                slot_free;
    logic                step_last;
    logic                take;
    logic                step_go;
    logic [TIME_W:0]     end_sum;
    logic [TIME_W-1:0]   end_time;

    t_cell_ctrl          cell_ctrl;
    t_cell_link          cell_out [NUM_CORES];
    t_cell_link          cell_in  [NUM_CORES];
    t_cell_link          wrap_link;

    // Status shared by the controller and datapath
    assign in_accept = i_in_valid && o_in_ready;
    assign bad_want  = (i_cores_wanted == '0) || ({1'b0, i_cores_wanted} > NC_LIMIT);
    assign slot_free = !r_out_valid || i_out_ready;
    assign step_last = (r_step == STEP_END);
    assign take      = (r_left != '0) && (cell_out[0].free_time <= r_start);
    assign step_go   = !take || slot_free;
    assign end_sum   = {1'b0, r_start} + {1'b0, r_run};
    assign end_time  = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];

    // Close the ring; the head writes the end time into a core it takes
    always_comb begin
        wrap_link = cell_out[0];
        if (r_state == ST_ASSIGN && take) begin
            wrap_link.free_time = end_time;
        end
    end

    // Row of cells, each fed by its right neighbor
    for (genvar g = 0; g < NUM_CORES; g++) begin : g_cell
        if (g == NUM_CORES - 1) begin : g_tail
            assign cell_in[g] = wrap_link;
        end else begin : g_body
            assign cell_in[g] = cell_out[g+1];
        end

        pjcs_cell #(
            .CNT_W (KW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_next  (cell_in[g]),
            .o_link  (cell_out[g])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = bad_want ? ST_ERR : ST_COUNT;
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_COUNT: begin
                if (step_last) begin
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                if (step_last) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_ASSIGN;
            end
            ST_ASSIGN: begin
                if (step_go && step_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb begin
        o_in_ready     = 1'b0;
        cell_ctrl.op   = CELL_HOLD;
        cell_ctrl.rank = r_want;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_accept) begin
                    cell_ctrl.op = CELL_LOAD;
                end
            end
            ST_COUNT:  cell_ctrl.op = CELL_COUNT;
            ST_MARK:   cell_ctrl.op = CELL_MARK;
            ST_PICK:   cell_ctrl.op = CELL_ROTATE;
            ST_ASSIGN: cell_ctrl.op = step_go ? CELL_ROTATE : CELL_HOLD;
            default:   cell_ctrl.op = CELL_HOLD;
        endcase
    end

    // Datapath and result register
    always_comb begin
        n_step       = r_step;
        n_left       = r_left;
        n_job_id     = r_job_id;
        n_arrival    = r_arrival;
        n_want       = r_want;
        n_run        = r_run;
        n_kth        = r_kth;
        n_start      = r_start;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_job_id = r_out_job_id;
        n_out_start  = r_out_start;
        n_out_end    = r_out_end;
        n_out_core   = r_out_core;
        n_out_last   = r_out_last;
        n_out_error  = r_out_error;

        // Capture the job
        if (r_state == ST_IDLE && in_accept) begin
            n_job_id  = i_job_id;
            n_arrival = i_arrival_time;
            n_want    = i_cores_wanted;
            n_run     = i_run_time;
            n_left    = KW'(i_cores_wanted);
            n_step    = '0;
        end

        // Advance the ring step counter
        if (r_state == ST_COUNT || r_state == ST_PICK ||
            (r_state == ST_ASSIGN && step_go)) begin
            n_step = step_last ? '0 : r_step + CW'(1);
        end

        // Collect the ranked free time as it passes the head
        if (r_state == ST_MARK) begin
            n_kth = '0;
        end
        if (r_state == ST_PICK && cell_out[0].flag) begin
            n_kth = cell_out[0].free_time;
        end

        // Start at the later of arrival and the ranked free time
        if (r_state == ST_CALC) begin
            n_start = (r_kth < r_arrival) ? r_arrival : r_kth;
        end

        // Emit the rejection transaction
        if (r_state == ST_ERR && slot_free) begin
            n_out_valid  = 1'b1;
            n_out_job_id = r_job_id;
            n_out_start  = '0;
            n_out_end    = '0;
            n_out_core   = '0;
            n_out_last   = 1'b1;
            n_out_error  = 1'b1;
        end

        // Emit one transaction per core taken at the head
        if (r_state == ST_ASSIGN && take && slot_free) begin
            n_out_valid  = 1'b1;
            n_out_job_id = r_job_id;
            n_out_start  = r_start;
            n_out_end    = end_time;
            n_out_core   = CORE_W'(r_step);
            n_out_last   = (r_left == KW'(1));
            n_out_error  = 1'b0;
            n_left       = r_left - KW'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_step       <= n_step;
        r_left       <= n_left;
        r_job_id     <= n_job_id;
        r_arrival    <= n_arrival;
        r_want       <= n_want;
        r_run        <= n_run;
        r_kth        <= n_kth;
        r_start      <= n_start;
        r_out_job_id <= n_out_job_id;
        r_out_start  <= n_out_start;
        r_out_end    <= n_out_end;
        r_out_core   <= n_out_core;
        r_out_last   <= n_out_last;
        r_out_error  <= n_out_error;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_job_id = r_out_job_id;
    assign o_start_time = r_out_start;
    assign o_end_time   = r_out_end;
    assign o_core_index = r_out_core;
    assign o_last       = r_out_last;
    assign o_error      = r_out_error;

    // The assignment pass must take exactly the requested number of cores
    a_all_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ASSIGN && step_go && step_last) |->
            (r_left == '0 || (r_left == KW'(1) && take)))
        else $error("assignment pass ended with cores still owed");

    // A job is worked on alone: no second transaction right after acceptance
    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // Rejections carry zero timing fields and close the job
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |->
            (o_last && o_start_time == '0 && o_end_time == '0 && o_core_index == '0))
        else $error("malformed rejection result");

endmodule

`default_nettype wire
